// ===== rtl/motor_command_frame_crc_macros.svh =====
// motor_command_frame_crc_macros.svh: assertion macros for the frame builder
// expects clk and arst_n in the scope where a macro is used
`ifndef MOTOR_COMMAND_FRAME_CRC_MACROS_SVH
`define MOTOR_COMMAND_FRAME_CRC_MACROS_SVH

// same-cycle implication
`define MCFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcfc check failed");

// next-cycle implication
`define MCFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcfc check failed");

`endif

// ===== rtl/mcfc_pkg.sv =====
// mcfc_pkg: types, constants and functions of the motor command frame builder
// no dependencies
package mcfc_pkg;

	localparam int unsigned FRAME_LEN = 34;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
	localparam int unsigned CRC_BYTES = 28;
	localparam int unsigned CNT_W     = $clog2(CRC_BYTES + 1);

	localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0] CRC_OUT_IDX  = IDX_W'(30);
	localparam logic [CNT_W-1:0] CRC_DONE_CNT = CNT_W'(CRC_BYTES);

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [7:0] SYNC0     = 8'hFE;
	localparam logic [7:0] SYNC1     = 8'hEE;
	localparam logic [7:0] MODE_TAIL = 8'hFF;

	typedef struct packed {
		logic [15:0]        damping_code;
		logic [15:0]        stiffness_code;
		logic signed [31:0] position_code;
		logic signed [15:0] speed_code;
		logic signed [15:0] torque_code;
		logic [7:0]         op_mode;
		logic [7:0]         motor_id;
	} cmd_t;

	// one byte of crc-32, msb first
	function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] d);
		logic [31:0] c;
		logic        fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[31] ^ d[i];
			c  = {c[30:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// frame byte at a given position
	function automatic logic [7:0] frame_sel(cmd_t c, logic [31:0] crc, logic [IDX_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			IDX_W'(0):  b = SYNC0;
			IDX_W'(1):  b = SYNC1;
			IDX_W'(2):  b = c.motor_id;
			IDX_W'(4):  b = c.op_mode;
			IDX_W'(5):  b = MODE_TAIL;
			IDX_W'(12): b = c.torque_code[7:0];
			IDX_W'(13): b = c.torque_code[15:8];
			IDX_W'(14): b = c.speed_code[7:0];
			IDX_W'(15): b = c.speed_code[15:8];
			IDX_W'(16): b = c.position_code[7:0];
			IDX_W'(17): b = c.position_code[15:8];
			IDX_W'(18): b = c.position_code[23:16];
			IDX_W'(19): b = c.position_code[31:24];
			IDX_W'(20): b = c.stiffness_code[7:0];
			IDX_W'(21): b = c.stiffness_code[15:8];
			IDX_W'(22): b = c.damping_code[7:0];
			IDX_W'(23): b = c.damping_code[15:8];
			IDX_W'(30): b = crc[7:0];
			IDX_W'(31): b = crc[15:8];
			IDX_W'(32): b = crc[23:16];
			IDX_W'(33): b = crc[31:24];
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/motor_command_frame_crc.sv =====
// motor_command_frame_crc: turns one motor command into a 34-byte frame with crc-32
// depends on mcfc_pkg and motor_command_frame_crc_macros.svh
//
//  channel | dir | tdata                         | tlast
//  s_*     | in  | one command, 112 bits         | -
//  m_*     | out | one frame byte                | final byte of frame
//
// a frame is 34 bytes, sent one byte per cycle on the output channel while m_tready is high
// a command passes the input, working and output registers before its first byte leaves; frames follow back to back
// a second command is held in the input register while a frame is sent
// crc runs one byte a cycle alongside the send, done before byte 30
// arst_n clears all control state; output stalls hold the byte counter but not the crc
`include "motor_command_frame_crc_macros.svh"

module motor_command_frame_crc
	import mcfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// motor_id[7:0], op_mode[15:8], torque_code[31:16], speed_code[47:32],
	// position_code[79:48], stiffness_code[95:80], damping_code[111:96]
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// frame_byte[7:0]
	output logic [7:0]   m_tdata,
	output logic         m_tlast
);

	logic             pend_valid_q;
	cmd_t             pend_q;
	logic             work_valid_q;
	cmd_t             work_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;

	logic             s_accept;
	logic             load_out;
	logic             work_done;
	logic             work_take;
	logic             crc_run;
	logic [IDX_W-1:0] crc_idx;
	logic [7:0]       crc_in_byte;
	logic [7:0]       out_byte;

	assign s_tready  = !pend_valid_q;
	assign s_accept  = s_tvalid && s_tready;
	assign load_out  = work_valid_q && (!out_valid_q || m_tready);
	assign work_done = load_out && (idx_q == LAST_IDX);
	assign work_take = pend_valid_q && (!work_valid_q || work_done);
	assign crc_run   = work_valid_q && (cnt_q != CRC_DONE_CNT);

	// words are little-endian, fed msb first: byte order 3,2,1,0,7,6,...
	assign crc_idx     = IDX_W'(cnt_q ^ CNT_W'(3));
	assign crc_in_byte = frame_sel(work_q, crc_q, crc_idx);
	assign out_byte    = frame_sel(work_q, crc_q, idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			work_valid_q <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s_accept) begin
				pend_valid_q <= 1'b1;
			end else if (work_take) begin
				pend_valid_q <= 1'b0;
			end

			if (work_take) begin
				work_valid_q <= 1'b1;
				idx_q        <= '0;
				cnt_q        <= '0;
			end else begin
				if (work_done) begin
					work_valid_q <= 1'b0;
				end
				if (load_out) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (crc_run) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pend_q <= cmd_t'(s_tdata);
		end
		if (work_take) begin
			work_q <= pend_q;
			crc_q  <= CRC_INIT;
		end else if (crc_run) begin
			crc_q <= crc_byte(crc_q, crc_in_byte);
		end
		if (load_out) begin
			out_data_q <= out_byte;
			out_last_q <= (idx_q == LAST_IDX);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`MCFC_ASSERT_NOW(a_crc_ready, load_out && (idx_q == CRC_OUT_IDX), cnt_q == CRC_DONE_CNT)
	`MCFC_ASSERT_NEXT(a_last_marked, work_done, m_tvalid && m_tlast)
	`MCFC_ASSERT_NEXT(a_pend_moves, pend_valid_q && !work_valid_q, work_valid_q && (idx_q == '0))
	`MCFC_ASSERT_NOW(a_idx_range, work_valid_q, idx_q <= LAST_IDX)

endmodule

// ===== verif/motor_command_frame_crc_checker.sv =====
// motor_command_frame_crc_checker: watches both stream channels of the frame builder,
// predicts the 34-word frame with its crc for every command taken and compares each word
// depends on mcfc_pkg for the command layout and frame constants
module motor_command_frame_crc_checker
	import mcfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	input  logic         m_tlast,
	output int           mismatches,
	output int           words_owed,
	output int           words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	frame_word_t frame_q[$];
	int          err_total;
	int          checked_total;

	// crc over bytes 0..27, read as seven little-endian words, msb first
	function automatic logic [31:0] frame_crc(logic [FRAME_LEN-1:0][7:0] f);
		logic [31:0] acc;
		logic [31:0] w;
		logic        fb;
		acc = CRC_INIT;
		for (int k = 0; k < 7; k++) begin
			w = {f[4*k+3], f[4*k+2], f[4*k+1], f[4*k]};
			for (int b = 31; b >= 0; b--) begin
				fb  = acc[31] ^ w[b];
				acc = {acc[30:0], 1'b0};
				if (fb) begin
					acc = acc ^ CRC_POLY;
				end
			end
		end
		return acc;
	endfunction

	task automatic queue_frame(cmd_t c);
		logic [FRAME_LEN-1:0][7:0] f;
		logic [31:0]               crc;
		f          = '0;
		f[0]       = SYNC0;
		f[1]       = SYNC1;
		f[2]       = c.motor_id;
		f[4]       = c.op_mode;
		f[5]       = MODE_TAIL;
		f[13:12]   = c.torque_code;
		f[15:14]   = c.speed_code;
		f[19:16]   = c.position_code;
		f[21:20]   = c.stiffness_code;
		f[23:22]   = c.damping_code;
		crc        = frame_crc(f);
		f[33:30]   = crc;
		for (int k = 0; k < FRAME_LEN; k++) begin
			frame_q.push_back({f[k], 1'(k == FRAME_LEN - 1)});
		end
	endtask

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("[%0t] frame word %0d: %s got %02h want %02h", $time, checked_total, what,
			got, want);
		err_total++;
	endtask

	always @(posedge clk) begin
		frame_word_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				queue_frame(cmd_t'(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (frame_q.size() == 0) begin
					report_mismatch("word with nothing owed", m_tdata, 8'h00);
				end else begin
					want = frame_q.pop_front();
					if (m_tdata !== want.data) begin
						report_mismatch("data", m_tdata, want.data);
					end
					if (m_tlast !== want.last) begin
						report_mismatch("tlast", 8'(m_tlast), 8'(want.last));
					end
				end
				checked_total++;
			end
		end
		mismatches    <= err_total;
		words_owed    <= frame_q.size();
		words_checked <= checked_total;
	end

endmodule

// ===== verif/motor_command_frame_crc_test.sv =====
// motor_command_frame_crc_test: drives commands into the frame builder with random stalls
// on both channels; the checker beside the block predicts and compares every frame word
// depends on mcfc_pkg, motor_command_frame_crc and motor_command_frame_crc_checker
module motor_command_frame_crc_test
	import mcfc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;
	logic         m_tlast;
	logic         calm;
	int           mismatches;
	int           words_owed;
	int           words_checked;
	int           cmds_sent;

	motor_command_frame_crc u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	motor_command_frame_crc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.words_owed    (words_owed),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// sink side: ready drops in bursts until the calm tail
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	function automatic cmd_t mk_cmd(logic [7:0] id, logic [7:0] mode, logic [15:0] tq,
		logic [15:0] sp, logic [31:0] pos, logic [15:0] kp, logic [15:0] kd);
		cmd_t c;
		c.motor_id       = id;
		c.op_mode        = mode;
		c.torque_code    = tq;
		c.speed_code     = sp;
		c.position_code  = pos;
		c.stiffness_code = kp;
		c.damping_code   = kd;
		return c;
	endfunction

	function automatic logic [15:0] edge16();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'h7FFF;
			2:       return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c = mk_cmd(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 16'($urandom));
		if ($urandom_range(0, 4) == 0) begin
			c.torque_code    = edge16();
			c.speed_code     = edge16();
			c.position_code  = {edge16(), edge16()};
			c.stiffness_code = edge16();
			c.damping_code   = edge16();
		end
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tdata  <= c;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		cmds_sent++;
	endtask

	task automatic drain_frames();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (words_owed != 0);
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		calm     <= 1'b0;
		cmds_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// field extremes and bit patterns
		send_cmd(mk_cmd(8'h00, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000));
		send_cmd(mk_cmd(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		send_cmd(mk_cmd(8'h01, 8'h80, 16'h8000, 16'h7FFF, 32'h8000_0000, 16'h0000, 16'hFFFF));
		send_cmd(mk_cmd(8'hFE, 8'h7F, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000));
		send_cmd(mk_cmd(8'h55, 8'hAA, 16'h5555, 16'hAAAA, 32'h5555_5555, 16'hAAAA, 16'h5555));
		send_cmd(mk_cmd(8'hAA, 8'h55, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA));
		send_cmd(mk_cmd(8'h12, 8'h34, 16'h0001, 16'hFFFF, 32'h0000_0001, 16'h0001, 16'h8000));
		send_cmd(mk_cmd(8'h80, 8'h01, 16'hFFFF, 16'h0001, 32'hFFFF_FFFF, 16'h8000, 16'h0001));
		// walking one through one byte lane of each field, position in steps of four bits
		for (int b = 0; b < 8; b++) begin
			send_cmd(mk_cmd(8'(1 << b), 8'(8'h80 >> b), 16'(1 << (b + 8)), 16'(1 << b),
				32'(1 << (b * 4)), 16'(1 << (b + 8)), 16'(1 << b)));
		end
		drain_frames();

		for (int i = 0; i < 220; i++) begin
			if (i == 180) begin
				calm <= 1'b1;
			end
			if (i % 60 == 30 && !calm) begin
				drain_frames();
			end
			send_cmd(random_cmd());
		end
		drain_frames();
		repeat (40) @(posedge clk);

		$display("%0d commands framed, %0d frame words checked", cmds_sent, words_checked);
		$display("field extremes, walking bits, random fields, stalls on both channels");
		if (mismatches == 0 && words_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mcfc_pkg.sv
rtl/motor_command_frame_crc.sv
verif/motor_command_frame_crc_checker.sv
verif/motor_command_frame_crc_test.sv
